// ----- hdl/byte_wise_prbs_scrambler_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the byte-wise PRBS scrambler
// Clocked, reset-qualified property wrappers shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef BYTE_WISE_PRBS_SCRAMBLER_CORE_MACROS_SVH
`define BYTE_WISE_PRBS_SCRAMBLER_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BPSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BPSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bpsc_pkg.sv -----
// ---------------------------------------------------------------------------
// bpsc_pkg
// Shared types and constants of the byte-wise PRBS scrambler.
// ---------------------------------------------------------------------------
`default_nettype none

package bpsc_pkg;

    // Default geometry
    localparam int REG_WIDTH_DEF = 32;
    localparam int POS_BITS_DEF  = 20;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_LEN_W  = 20;

    // Stream words
    localparam int BYTE_W = 8;

    // Scrambler constants
    localparam logic [CFG_DATA_W-1:0] DVB_START  = 32'h0000_00A9;
    localparam logic [7:0]            DVB_PACKET = 8'd188;
    localparam logic [BYTE_W-1:0]     FILL_BYTE  = 8'hFF;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] POLY_RST  = 32'h0000_0110;
    localparam logic [CFG_DATA_W-1:0] START_RST = 32'h0000_0000;
    localparam logic [CFG_LEN_W-1:0]  FLEN_RST  = 20'd1;
    localparam logic [CFG_LEN_W-1:0]  ICNT_RST  = 20'd0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_POLY  = 3'd0,
        CFG_START = 3'd1,
        CFG_FLEN  = 3'd2,
        CFG_ICNT  = 3'd3,
        CFG_MIX   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] poly;
        logic [CFG_DATA_W-1:0] start_value;
        logic [CFG_LEN_W-1:0]  frame_length;
        logic [CFG_LEN_W-1:0]  init_count;
        logic                  mix_input;
    } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/bpsc_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// bpsc_cfg_regs
// Write-only configuration register file of the scrambler.
// ---------------------------------------------------------------------------
`default_nettype none

module bpsc_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bpsc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [bpsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output bpsc_pkg::cfg_t                       cfg
);

    bpsc_pkg::cfg_t cfg_reg;
    bpsc_pkg::cfg_t cfg_next;

    // Decode the write; unknown indexes drop the data
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (bpsc_pkg::cfg_index_t'(cfg_addr))
                bpsc_pkg::CFG_POLY:  cfg_next.poly         = cfg_wdata;
                bpsc_pkg::CFG_START: cfg_next.start_value  = cfg_wdata;
                bpsc_pkg::CFG_FLEN:
                    cfg_next.frame_length = cfg_wdata[bpsc_pkg::CFG_LEN_W-1:0];
                bpsc_pkg::CFG_ICNT:
                    cfg_next.init_count   = cfg_wdata[bpsc_pkg::CFG_LEN_W-1:0];
                bpsc_pkg::CFG_MIX:   cfg_next.mix_input    = cfg_wdata[0];
                default:             cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poly         <= bpsc_pkg::POLY_RST;
            cfg_reg.start_value  <= bpsc_pkg::START_RST;
            cfg_reg.frame_length <= bpsc_pkg::FLEN_RST;
            cfg_reg.init_count   <= bpsc_pkg::ICNT_RST;
            cfg_reg.mix_input    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hdl/bpsc_lfsr8.sv -----
// ---------------------------------------------------------------------------
// bpsc_lfsr8
// Eight unrolled Fibonacci LFSR steps with parity feedback.
// ---------------------------------------------------------------------------
`default_nettype none

module bpsc_lfsr8 #(
    parameter int REG_WIDTH = bpsc_pkg::REG_WIDTH_DEF
) (
    input  wire logic [REG_WIDTH-1:0] state_in,
    input  wire logic [REG_WIDTH-1:0] poly,
    output logic      [REG_WIDTH-1:0] state_out
);

    localparam int STEPS = 8;

    always_comb
    begin
        logic [REG_WIDTH-1:0] acc;
        acc = state_in;
        for (int k = 0; k < STEPS; k++)
        begin
            // shift left, feed parity of the tapped bits into bit 0
            acc = {acc[REG_WIDTH-2:0], ^(acc & poly)};
        end
        state_out = acc;
    end

endmodule

`default_nettype wire

// ----- hdl/byte_wise_prbs_scrambler_core.sv -----
// ---------------------------------------------------------------------------
// byte_wise_prbs_scrambler_core
// Byte-wise LFSR energy-dispersal scrambler on a stream interface.
// Path: an accepted input passes the input register, then the result
//   register; one word per cycle sustained while the sink does not stall,
//   with the eight-step LFSR advance between the two registers.
// Reset: async active low; clears valids, slot counter, phase and LFSR,
//   and loads the configuration registers with their defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module byte_wise_prbs_scrambler_core #(
    parameter int REG_WIDTH = bpsc_pkg::REG_WIDTH_DEF,   // 2 .. 32
    parameter int POS_BITS  = bpsc_pkg::POS_BITS_DEF     // 8 .. 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    // Configuration write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [bpsc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [bpsc_pkg::CFG_DATA_W-1:0] cfg_wdata,

    // Input stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [bpsc_pkg::BYTE_W-1:0]     s_axis_tdata,   // [7:0] in_byte

    // Output stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [bpsc_pkg::BYTE_W-1:0]     m_axis_tdata,   // [7:0] out_byte
    output logic                                 m_axis_tlast    // frame_last
);

    // Length arithmetic must hold both the 20-bit register and 2^POS_BITS
    localparam int LEN_W = (POS_BITS + 1 > bpsc_pkg::CFG_LEN_W) ?
                           POS_BITS + 1 : bpsc_pkg::CFG_LEN_W;
    localparam int BW    = bpsc_pkg::BYTE_W;

    // -----------------------------------------------------------------------
    // Configuration
    // -----------------------------------------------------------------------
    bpsc_pkg::cfg_t cfg;

    bpsc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // -----------------------------------------------------------------------
    // Registers
    // -----------------------------------------------------------------------
    logic                 in_valid_reg;
    logic [BW-1:0]        in_byte_reg;
    logic                 out_valid_reg;
    logic [BW-1:0]        out_byte_reg;
    logic                 out_last_reg;
    logic [REG_WIDTH-1:0] sr_reg;
    logic [POS_BITS-1:0]  pos_reg;
    logic [7:0]           phase_reg;

    logic [REG_WIDTH-1:0] sr_next;
    logic [POS_BITS-1:0]  pos_next;
    logic [7:0]           phase_next;
    logic [BW-1:0]        out_byte_next;
    logic                 out_last_next;

    // Move the held word into the result register when that slot frees up;
    // the input side keeps flowing as long as the held word can move on.
    logic advance;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || !out_valid_reg || m_axis_tready;

    // -----------------------------------------------------------------------
    // Effective frame length and fill count
    // -----------------------------------------------------------------------
    logic [LEN_W-1:0] pos_limit;
    logic [LEN_W-1:0] flen_raw;
    logic [LEN_W-1:0] flen;
    logic [LEN_W-1:0] icnt_raw;
    logic [LEN_W-1:0] icnt;
    logic [LEN_W-1:0] pos_ext;
    logic [LEN_W-1:0] pos_inc;

    assign pos_limit = LEN_W'(1) << POS_BITS;
    assign flen_raw  = LEN_W'(cfg.frame_length);
    assign icnt_raw  = LEN_W'(cfg.init_count);
    assign pos_ext   = LEN_W'(pos_reg);
    assign pos_inc   = pos_ext + LEN_W'(1);

    always_comb
    begin
        // zero length acts as one; clamp to the slot counter range
        if (flen_raw == '0)
            flen = LEN_W'(1);
        else if (flen_raw > pos_limit)
            flen = pos_limit;
        else
            flen = flen_raw;
        icnt = (icnt_raw > flen) ? flen : icnt_raw;
    end

    // -----------------------------------------------------------------------
    // Frame-start load value
    // -----------------------------------------------------------------------
    logic [REG_WIDTH-1:0] poly_m;
    logic [REG_WIDTH-1:0] ones_fill;
    logic [REG_WIDTH-1:0] load_val;

    assign poly_m = cfg.poly[REG_WIDTH-1:0];

    // all-ones as wide as the polynomial: bit i set if any tap at or above i
    always_comb
    begin
        for (int i = 0; i < REG_WIDTH; i++)
        begin
            ones_fill[i] = |(poly_m >> i);
        end
    end

    assign load_val = (cfg.start_value != '0) ? cfg.start_value[REG_WIDTH-1:0] : ones_fill;

    // -----------------------------------------------------------------------
    // Slot processing
    // -----------------------------------------------------------------------
    logic                 frame_start;
    logic [REG_WIDTH-1:0] sr_cur;
    logic [7:0]           phase_cur;
    logic [REG_WIDTH-1:0] sr_adv;
    logic [REG_WIDTH+BW-1:0] sr_adv_ext;
    logic                 fill_slot;
    logic                 dvb_mode;
    logic [BW-1:0]        seq_byte;

    assign frame_start = (pos_reg == '0);
    assign sr_cur      = frame_start ? load_val : sr_reg;
    assign phase_cur   = frame_start ? 8'd0 : phase_reg;

    bpsc_lfsr8 #(
        .REG_WIDTH (REG_WIDTH)
    ) u_lfsr (
        .state_in  (sr_cur),
        .poly      (poly_m),
        .state_out (sr_adv)
    );

    assign sr_adv_ext = {{BW{1'b0}}, sr_adv};
    assign fill_slot  = (pos_ext < icnt);
    assign dvb_mode   = (cfg.start_value == bpsc_pkg::DVB_START);

    always_comb
    begin
        // leading fill slots hold the register; others advance it
        if (fill_slot)
        begin
            seq_byte = bpsc_pkg::FILL_BYTE;
            sr_next  = sr_cur;
        end
        else
        begin
            sr_next = sr_adv;
            // sync byte position of a DVB packet takes a zero sequence byte
            if (dvb_mode && (phase_cur == 8'd0))
                seq_byte = '0;
            else
                seq_byte = sr_adv_ext[BW-1:0];
        end

        out_byte_next = cfg.mix_input ? (seq_byte ^ in_byte_reg) : seq_byte;
        out_last_next = (pos_inc >= flen);

        if (out_last_next)
        begin
            pos_next   = '0;
            phase_next = 8'd0;
        end
        else
        begin
            pos_next   = pos_inc[POS_BITS-1:0];
            phase_next = ((phase_cur + 8'd1) >= bpsc_pkg::DVB_PACKET) ?
                         8'd0 : phase_cur + 8'd1;
        end
    end

    // -----------------------------------------------------------------------
    // Control and state registers
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sr_reg        <= '0;
            pos_reg       <= '0;
            phase_reg     <= 8'd0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                sr_reg    <= sr_next;
                pos_reg   <= pos_next;
                phase_reg <= phase_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;

        if (advance)
        begin
            out_byte_reg <= out_byte_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- hdl/bpsc_checker.sv -----
// ---------------------------------------------------------------------------
// bpsc_checker
// Port-level checks of the scrambler stream behavior, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "byte_wise_prbs_scrambler_core_macros.svh"

module bpsc_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    input  wire logic                        s_axis_tready,
    input  wire logic                        m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    input  wire logic [bpsc_pkg::BYTE_W-1:0] m_axis_tdata,
    input  wire logic                        m_axis_tlast
);

    logic in_fire;
    logic out_stall;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // a held result must not change while the sink stalls
    `BPSC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "output word changed under stall")

    // input back-pressure only comes from a full, stalled output
    `BPSC_ASSERT_IMPL(a_bp_cause, clk, rst_n, !s_axis_tready, out_stall,
        "input stalled without output stall")

    // every accept is followed by a valid word at the output register
    `BPSC_ASSERT_IMPL(a_latency, clk, rst_n, in_fire, ##2 m_axis_tvalid,
        "accepted word not presented in time")

endmodule

bind byte_wise_prbs_scrambler_core bpsc_checker u_bpsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Stream-level test of the byte-wise PRBS scrambler: a queue-fed driver
// offers input bytes, a predictor models the LFSR, slot counter and DVB
// packet phase, and a monitor checks every output word in order.
// ---------------------------------------------------------------------------

module tb_top;

    localparam int HOLD_CYCLES = 300;   // long output hold-off
    localparam int STUCK_LIMIT = 3000;  // cycles with no handshake at all
    localparam int RAND_PHASES = 12;
    localparam int PHASE_BYTES = 160;

    typedef struct packed {
        logic [bpsc_pkg::BYTE_W-1:0] out_byte;
        logic                        frame_last;
    } slot_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                            cfg_wr_en = 1'b0;
    logic [bpsc_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [bpsc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [bpsc_pkg::BYTE_W-1:0] s_axis_tdata  = '0;   // [7:0] in_byte

    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [bpsc_pkg::BYTE_W-1:0] m_axis_tdata;         // [7:0] out_byte
    logic                        m_axis_tlast;         // frame_last

    // Bytes waiting to be offered, and scrambled words still owed by the block
    logic [bpsc_pkg::BYTE_W-1:0] byte_q[$];
    slot_result_t                result_q[$];

    // Predictor state: register copies plus LFSR, slot counter, packet phase
    bpsc_pkg::cfg_t model_cfg;
    logic [31:0]    lfsr_state;
    logic [19:0]    slot_pos;
    int             pkt_phase;

    int  src_gap_pct  = 0;
    int  rx_stall_pct = 0;
    bit  rx_hold      = 1'b0;
    int  stuck_cycles = 0;
    int  err_cnt      = 0;
    int  bytes_in     = 0;
    int  words_checked = 0;
    int  frame_ends   = 0;
    int  fill_slots   = 0;
    int  dvb_zero_slots = 0;
    int  cfg_settings = 0;

    byte_wise_prbs_scrambler_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // -----------------------------------------------------------------------
    // Predictor: one input byte in, the scrambled word it must produce out.
    // Advances the model state exactly as the block does for one slot.
    // -----------------------------------------------------------------------
    function automatic slot_result_t scramble_slot(logic [bpsc_pkg::BYTE_W-1:0] in_byte);
        logic [20:0]  flen;
        logic [20:0]  icnt;
        logic [20:0]  pos;
        logic [31:0]  acc;
        slot_result_t res;
        flen = {1'b0, model_cfg.frame_length};
        icnt = {1'b0, model_cfg.init_count};
        pos  = {1'b0, slot_pos};
        // A zero frame length behaves as one slot; the fill run never outlasts the frame
        if (flen == 0)
            flen = 1;
        if (icnt > flen)
            icnt = flen;

        // Frame start: load the seed, or the smallest all-ones value covering the taps
        if (pos == 0)
        begin
            if (model_cfg.start_value != 0)
            begin
                lfsr_state = model_cfg.start_value;
            end
            else
            begin
                acc = '0;
                for (int k = 0; k < 32; k++)
                    if (acc < model_cfg.poly)
                        acc = {acc[30:0], 1'b1};
                lfsr_state = acc;
            end
            pkt_phase = 0;
        end

        if (pos < icnt)
        begin
            // Leading fill slots hold the LFSR
            res.out_byte = bpsc_pkg::FILL_BYTE;
            fill_slots++;
        end
        else
        begin
            acc = lfsr_state;
            for (int k = 0; k < 8; k++)
                acc = {acc[30:0], ^(acc & model_cfg.poly)};
            lfsr_state = acc;
            // DVB mode blanks the sync slot of every 188-byte packet
            if (model_cfg.start_value == bpsc_pkg::DVB_START && pkt_phase == 0)
            begin
                res.out_byte = '0;
                dvb_zero_slots++;
            end
            else
            begin
                res.out_byte = acc[7:0];
            end
        end

        if (model_cfg.mix_input)
            res.out_byte ^= in_byte;

        res.frame_last = (pos + 1 >= flen);
        if (res.frame_last)
        begin
            slot_pos  = '0;
            pkt_phase = 0;
        end
        else
        begin
            slot_pos  = pos[19:0] + 20'd1;
            pkt_phase = (pkt_phase + 1 >= int'(bpsc_pkg::DVB_PACKET)) ? 0 : pkt_phase + 1;
        end
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Driver: offer queued bytes, idle at random, predict on every accept
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                result_q.push_back(scramble_slot(s_axis_tdata));
                bytes_in++;
            end
            // Hold the word until taken; otherwise pick the next one or idle
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (byte_q.size() != 0 && $urandom_range(99) >= src_gap_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= byte_q.pop_front();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: stall at random, compare each taken word with the oldest
    // prediction
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin : check_word
            slot_result_t want;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("unexpected word: out_byte %02h frame_last %0b",
                           m_axis_tdata, m_axis_tlast);
                    err_cnt++;
                end
                else
                begin
                    want = result_q.pop_front();
                    words_checked++;
                    if (m_axis_tlast)
                        frame_ends++;
                    if (m_axis_tdata !== want.out_byte)
                    begin
                        $error("out_byte mismatch: expected %02h, got %02h",
                               want.out_byte, m_axis_tdata);
                        err_cnt++;
                    end
                    if (m_axis_tlast !== want.frame_last)
                    begin
                        $error("frame_last mismatch: expected %0b, got %0b",
                               want.frame_last, m_axis_tlast);
                        err_cnt++;
                    end
                end
            end
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: drop the run if neither side moves a word for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Wait until nothing is queued, offered or owed
    task automatic wait_idle();
        do
            @(negedge clk);
        while (byte_q.size() != 0 || result_q.size() != 0 || s_axis_tvalid);
    endtask

    // One register write per cycle; the enable stays high across a burst
    task automatic write_reg(bpsc_pkg::cfg_index_t idx,
                             logic [bpsc_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
    endtask

    // Write all five registers while the block is idle, mirror them in the model
    task automatic apply_config(logic [31:0] poly, logic [31:0] start,
                                logic [19:0] flen, logic [19:0] icnt, logic mix);
        wait_idle();
        write_reg(bpsc_pkg::CFG_POLY,  poly);
        write_reg(bpsc_pkg::CFG_START, start);
        write_reg(bpsc_pkg::CFG_FLEN,  {12'd0, flen});
        write_reg(bpsc_pkg::CFG_ICNT,  {12'd0, icnt});
        write_reg(bpsc_pkg::CFG_MIX,   {31'd0, mix});
        model_cfg.poly         = poly;
        model_cfg.start_value  = start;
        model_cfg.frame_length = flen;
        model_cfg.init_count   = icnt;
        model_cfg.mix_input    = mix;
        cfg_settings++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Queue random bytes under the given idle pattern
    task automatic run_random(int count, int src_pct, int rx_pct);
        src_gap_pct  = src_pct;
        rx_stall_pct = rx_pct;
        for (int i = 0; i < count; i++)
            byte_q.push_back(bpsc_pkg::BYTE_W'($urandom_range(255)));
    endtask

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial
    begin : stimulus
        logic [31:0] poly;
        logic [31:0] start;
        logic [19:0] flen;
        logic [19:0] icnt;
        int          src_pct;
        int          rx_pct;

        model_cfg  = '{bpsc_pkg::POLY_RST, bpsc_pkg::START_RST, bpsc_pkg::FLEN_RST,
                       bpsc_pkg::ICNT_RST, 1'b0};
        lfsr_state = '0;
        slot_pos   = '0;
        pkt_phase  = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: zero seed loads the all-ones value covering 0x110,
        // one-slot frames, input ignored
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h80);

        // Zero frame length acts as one slot; oversized fill count clamps to it
        apply_config(bpsc_pkg::POLY_RST, 32'h0, 20'd0, 20'd5, 1'b1);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h5A);

        // No taps and zero seed: register stays at zero
        apply_config(32'h0, 32'h0, 20'd4, 20'd0, 1'b0);
        byte_q.push_back(8'h01);
        byte_q.push_back(8'hFE);
        byte_q.push_back(8'hA5);
        byte_q.push_back(8'h3C);

        // All ones everywhere, largest frame and fill count
        apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 20'hFFFFF, 1'b1);
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h7F);

        // Shrink the frame mid-run: the next slot already passes the end;
        // DVB seed blanks the first slot of the new frame
        apply_config(32'h0000_6000, bpsc_pkg::DVB_START, 20'd2, 20'd0, 1'b0);
        byte_q.push_back(8'h12);
        byte_q.push_back(8'hED);
        byte_q.push_back(8'h44);
        byte_q.push_back(8'hBB);

        // Random part: new settings per phase, rotating through idle patterns
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case ($urandom_range(5))
                0: poly = bpsc_pkg::POLY_RST;
                1: poly = 32'h0000_6000;
                2: poly = $urandom;
                3: poly = 32'hFFFF_FFFF;
                4: poly = 32'h8000_0057;
                default: poly = $urandom & 32'h0000_FFFF;
            endcase
            case ($urandom_range(4))
                0: start = 32'h0;
                1: start = bpsc_pkg::DVB_START;
                2: start = $urandom;
                3: start = 32'hFFFF_FFFF;
                default: start = bpsc_pkg::DVB_START;
            endcase
            case ($urandom_range(5))
                0: flen = 20'd0;
                1: flen = 20'd1;
                2: flen = 20'($urandom_range(2, 12));
                3: flen = 20'($urandom_range(13, 200));
                4: flen = 20'($urandom_range(188, 600));
                default: flen = 20'hFFFFF;
            endcase
            case ($urandom_range(3))
                0: icnt = 20'd0;
                1: icnt = 20'($urandom_range(0, 8));
                2: icnt = 20'($urandom_range(0, 40));
                default: icnt = 20'hFFFFF;
            endcase
            // Pin the first two phases to long DVB frames so the packet phase wraps
            if (p < 2)
            begin
                start = bpsc_pkg::DVB_START;
                flen  = (p == 0) ? 20'hFFFFF : 20'd376;
                icnt  = (p == 0) ? 20'd0 : 20'd2;
            end
            apply_config(poly, start, flen, icnt, 1'($urandom_range(1)));

            case (p % 4)
                0:
                begin
                    src_pct = 0;
                    rx_pct  = 0;
                end
                1:
                begin
                    src_pct = 46;
                    rx_pct  = 0;
                end
                2:
                begin
                    src_pct = 0;
                    rx_pct  = 46;
                end
                default:
                begin
                    src_pct = 15;
                    rx_pct  = 15;
                end
            endcase
            if (p == 4)
            begin
                // Back-pressure: hold the output while the sender keeps offering
                src_pct = 0;
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (HOLD_CYCLES) @(negedge clk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            run_random(PHASE_BYTES, src_pct, rx_pct);
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (result_q.size() != 0)
        begin
            $error("%0d expected words never arrived", result_q.size());
            err_cnt++;
        end

        $display("Run: %0d bytes in, %0d words checked, %0d frame ends, %0d register settings",
                 bytes_in, words_checked, frame_ends, cfg_settings);
        $display("Run: %0d fill slots, %0d DVB sync blanks, one %0d-cycle output hold-off",
                 fill_slots, dvb_zero_slots, HOLD_CYCLES);
        if (err_cnt == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
